// ===== src/sample_adaptive_residual_decoder_unit_macros.svh =====
// Assertion macros for the sample adaptive residual decoder.
// Included by the top level only; needs clk and rst_n in scope.
`ifndef SAMPLE_ADAPTIVE_RESIDUAL_DECODER_UNIT_MACROS_SVH
`define SAMPLE_ADAPTIVE_RESIDUAL_DECODER_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define SARD_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SARD_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/sard_pkg.sv =====
// Shared types and constants for the sample adaptive residual decoder.
// No dependencies.
package sard_pkg;
    typedef enum logic [1:0] {PH_IDLE, PH_RAW, PH_UNARY, PH_REM} phase_t;
    typedef enum logic [3:0] {
        S_WAIT, S_INIT, S_BIT, S_KRD, S_KCMP, S_UPD, S_FIN, S_EMIT
    } state_t;
    localparam logic [2:0] REG_PIXELS = 3'd0;
    localparam logic [2:0] REG_BANDS  = 3'd1;
    localparam logic [2:0] REG_DRANGE = 3'd2;
    localparam logic [2:0] REG_UMAX   = 3'd3;
    localparam logic [2:0] REG_RESC   = 3'd4;
    localparam logic [2:0] REG_ICNT   = 3'd5;
    localparam logic [2:0] REG_IK     = 3'd6;
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
    typedef struct packed {
        logic [24:0] pixels;
        logic [8:0]  bands;
        logic [4:0]  drange;
        logic [5:0]  umax;
        logic [3:0]  resc;
        logic [3:0]  icnt;
        logic [3:0]  ik;
    } cfg_t;
endpackage

// ===== src/sard_stats_mem.sv =====
// Per-band statistics memory: counter and accumulator, one port each way.
// Depends on nothing but its parameter.
module sard_stats_mem #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [10:0]   wcount,
    input  logic [31:0]   waccum,
    input  logic [AW-1:0] raddr,
    output logic [10:0]   rcount,
    output logic [31:0]   raccum
);
    logic [42:0] mem [DEPTH];
    logic [42:0] rdata_reg;
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wcount, waccum};
        end
        rdata_reg <= mem[raddr];
    end
    assign rcount = rdata_reg[42:32];
    assign raccum = rdata_reg[31:0];
endmodule

// ===== src/sample_adaptive_residual_decoder_unit.sv =====
// Sample adaptive residual decoder, top level: bit-serial parser, k search,
// statistics update and output register. Uses sard_pkg, sard_stats_mem, macros.
// Usage: in_valid/in_ready carry command and compressed_byte. A begin command
//   (command 0) resets the parser and sweeps every band's statistics, one band
//   per cycle, and no input is taken until the sweep ends. A byte (command 1)
//   is shifted MSB first, one bit per cycle while the parser is not held by
//   a k search, an update or a stall. Each completed sample gives one
//   transfer on out_valid/out_ready carrying residual, band, last_of_byte,
//   image_done.
// Sequence: a byte is accepted in S_WAIT and shifted bit by bit in S_BIT,
//   where its end is seen; once the image is done its bits are not shifted.
//   A unary terminator adds a memory read (S_KRD) and the compare steps that
//   find k (S_KCMP); a completed sample adds the update (S_UPD) and hand-off
//   (S_FIN). A completed result is held until the next completion or the byte
//   end, when it moves to the output register; the byte end hand-off is S_EMIT.
// Reset: parser idle, bytes ignored until a begin command.
// Stall: while the output register and held result are full and out_ready is
//   low the parser waits; no input is accepted until the byte is fully processed.
// Config: cfg_we, cfg_index, cfg_data; write only while idle.
`include "sample_adaptive_residual_decoder_unit_macros.svh"
module sample_adaptive_residual_decoder_unit #(
    parameter int MAX_BANDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  compressed_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] residual,
    output logic [7:0]  band,
    output logic        last_of_byte,
    output logic        image_done
);
    localparam int AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BW = $clog2(MAX_BANDS + 1);

    sard_pkg::cfg_t cfg_reg;
    sard_pkg::state_t state_reg, state_next;
    sard_pkg::phase_t phase_reg;
    logic [7:0]  sh_reg;
    logic [3:0]  nbit_reg;
    logic [4:0]  bits_left_reg;
    logic [5:0]  ucnt_reg;
    logic [15:0] pval_reg;
    logic [24:0] pix_reg;
    logic [BW-1:0] bidx_reg;
    logic [BW-1:0] sweep_reg;
    logic [3:0]  k_reg;
    logic [32:0] rhs_reg;
    logic [43:0] ck_reg;
    logic [10:0] cnt_reg;
    logic [31:0] acc_reg;
    logic        done_reg;
    logic        pvalid_reg;
    logic [15:0] pres_reg;
    logic [7:0]  pband_reg;
    logic        pdone_reg;
    logic        ovalid_reg;
    logic [15:0] ores_reg;
    logic [7:0]  oband_reg;
    logic        olast_reg;
    logic        odone_reg;

    logic [24:0] eff_pix;
    logic [BW-1:0] eff_bands;
    logic [4:0]  eff_d;
    logic [5:0]  eff_u;
    logic [3:0]  eff_r;
    logic [3:0]  eff_c;
    logic [10:0] c0;
    logic [31:0] a0;
    logic [22:0] a0_mul;
    logic        we;
    logic [AW-1:0] waddr;
    logic [10:0] wcount;
    logic [31:0] waccum;
    logic [10:0] rcount;
    logic [31:0] raccum;
    logic [10:0] lim;
    logic        bit_in;
    logic        more_bits;
    logic        out_free;
    logic        fin_go;
    logic        push;

    always_comb
    begin
        eff_pix = (cfg_reg.pixels == '0) ? 25'd1 :
            (cfg_reg.pixels > 25'd16777216) ? 25'd16777216 : cfg_reg.pixels;
        eff_bands = (cfg_reg.bands == '0) ? BW'(1) :
            ({23'd0, cfg_reg.bands} > MAX_BANDS) ? BW'(MAX_BANDS) : BW'(cfg_reg.bands);
        eff_d = (cfg_reg.drange < 5'd2) ? 5'd2 :
            (cfg_reg.drange > 5'd16) ? 5'd16 : cfg_reg.drange;
        eff_u = (cfg_reg.umax == '0) ? 6'd1 :
            (cfg_reg.umax > 6'd32) ? 6'd32 : cfg_reg.umax;
        eff_r = (cfg_reg.resc < 4'd4) ? 4'd4 :
            (cfg_reg.resc > 4'd11) ? 4'd11 : cfg_reg.resc;
        eff_c = (cfg_reg.icnt == '0) ? 4'd1 :
            (cfg_reg.icnt > 4'd8) ? 4'd8 : cfg_reg.icnt;
        c0 = 11'd1 << eff_c;
        a0_mul = (23'd3 << (5'(cfg_reg.ik) + 5'd6)) - 23'd49;
        a0 = 32'(({9'd0, a0_mul} << eff_c) >> 7);
        lim = 11'((12'd1 << eff_r) - 12'd1);
        bit_in = sh_reg[7];
        more_bits = (nbit_reg != 4'd0) && (phase_reg != sard_pkg::PH_IDLE);
        out_free = !ovalid_reg || out_ready;
        fin_go = !pvalid_reg || out_free;
        push = (state_reg == sard_pkg::S_FIN && fin_go && pvalid_reg) ||
               (state_reg == sard_pkg::S_EMIT && out_free);
    end

    assign in_ready = (state_reg == sard_pkg::S_WAIT);

    sard_stats_mem #(.DEPTH(MAX_BANDS), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wcount(wcount), .waccum(waccum),
        .raddr(AW'(bidx_reg)), .rcount(rcount), .raccum(raccum)
    );

    always_comb
    begin
        we = 1'b0;
        waddr = AW'(bidx_reg);
        wcount = c0;
        waccum = a0;
        if (state_reg == sard_pkg::S_INIT)
        begin
            we = 1'b1;
            waddr = AW'(sweep_reg);
        end
        else if (state_reg == sard_pkg::S_UPD && pix_reg != '0)
        begin
            we = 1'b1;
            if (cnt_reg < lim)
            begin
                waccum = acc_reg + {16'd0, pval_reg};
                wcount = cnt_reg + 11'd1;
            end
            else
            begin
                waccum = 32'(({1'b0, acc_reg} + {17'd0, pval_reg} + 33'd1) >> 1);
                wcount = 11'((12'(cnt_reg) + 12'd1) >> 1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sard_pkg::S_WAIT:
                if (in_valid)
                begin
                    state_next = (command == sard_pkg::CMD_BEGIN) ? sard_pkg::S_INIT
                                                                  : sard_pkg::S_BIT;
                end
            sard_pkg::S_INIT:
                if (sweep_reg + BW'(1) >= eff_bands) state_next = sard_pkg::S_WAIT;
            sard_pkg::S_BIT:
                if (!more_bits)
                    state_next = pvalid_reg ? sard_pkg::S_EMIT : sard_pkg::S_WAIT;
                else if (phase_reg == sard_pkg::PH_UNARY && bit_in)
                    state_next = sard_pkg::S_KRD;
                else if ((phase_reg == sard_pkg::PH_RAW || phase_reg == sard_pkg::PH_REM)
                         && bits_left_reg <= 5'd1)
                    state_next = sard_pkg::S_UPD;
            sard_pkg::S_KRD: state_next = sard_pkg::S_KCMP;
            sard_pkg::S_KCMP:
                if ({1'b0, k_reg} >= eff_d - 5'd2 || (ck_reg << 1) > {11'd0, rhs_reg})
                    state_next = (k_reg == 4'd0) ? sard_pkg::S_UPD : sard_pkg::S_BIT;
            sard_pkg::S_UPD: state_next = sard_pkg::S_FIN;
            sard_pkg::S_FIN:
                if (fin_go) state_next = sard_pkg::S_BIT;
            sard_pkg::S_EMIT:
                if (out_free) state_next = sard_pkg::S_WAIT;
            default: state_next = sard_pkg::S_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pixels: 25'd1, bands: 9'd1, drange: 5'd16, umax: 6'd32,
                         resc: 4'd4, icnt: 4'd8, ik: 4'd0};
            state_reg <= sard_pkg::S_WAIT;
            phase_reg <= sard_pkg::PH_IDLE;
            bits_left_reg <= '0;
            ucnt_reg <= '0;
            pval_reg <= '0;
            pix_reg <= '0;
            bidx_reg <= '0;
            done_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            nbit_reg <= '0;
            sweep_reg <= '0;
            k_reg <= '0;
            pvalid_reg <= 1'b0;
            pres_reg <= '0;
            pband_reg <= '0;
            pdone_reg <= 1'b0;
            ores_reg <= '0;
            oband_reg <= '0;
            olast_reg <= 1'b0;
            odone_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sard_pkg::REG_PIXELS: cfg_reg.pixels <= cfg_data;
                    sard_pkg::REG_BANDS:  cfg_reg.bands <= cfg_data[8:0];
                    sard_pkg::REG_DRANGE: cfg_reg.drange <= cfg_data[4:0];
                    sard_pkg::REG_UMAX:   cfg_reg.umax <= cfg_data[5:0];
                    sard_pkg::REG_RESC:   cfg_reg.resc <= cfg_data[3:0];
                    sard_pkg::REG_ICNT:   cfg_reg.icnt <= cfg_data[3:0];
                    sard_pkg::REG_IK:     cfg_reg.ik <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (push) ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                sard_pkg::S_WAIT:
                    if (in_valid)
                    begin
                        nbit_reg <= 4'd8;
                        if (command == sard_pkg::CMD_BEGIN)
                        begin
                            sweep_reg <= '0;
                            pix_reg <= '0;
                            bidx_reg <= '0;
                            done_reg <= 1'b0;
                            pval_reg <= '0;
                            ucnt_reg <= '0;
                            phase_reg <= sard_pkg::PH_RAW;
                            bits_left_reg <= eff_d;
                        end
                    end
                sard_pkg::S_INIT: sweep_reg <= sweep_reg + BW'(1);
                sard_pkg::S_BIT:
                    if (more_bits)
                    begin
                        nbit_reg <= nbit_reg - 4'd1;
                        if (phase_reg == sard_pkg::PH_UNARY)
                        begin
                            if (!bit_in)
                            begin
                                ucnt_reg <= ucnt_reg + 6'd1;
                                if (ucnt_reg + 6'd1 >= eff_u)
                                begin
                                    phase_reg <= sard_pkg::PH_RAW;
                                    bits_left_reg <= eff_d;
                                    pval_reg <= '0;
                                end
                            end
                            else pval_reg <= {10'd0, ucnt_reg};
                        end
                        else
                        begin
                            pval_reg <= {pval_reg[14:0], bit_in};
                            if (bits_left_reg != '0) bits_left_reg <= bits_left_reg - 5'd1;
                        end
                    end
                sard_pkg::S_KRD: k_reg <= '0;
                sard_pkg::S_KCMP:
                    if ({1'b0, k_reg} >= eff_d - 5'd2 || (ck_reg << 1) > {11'd0, rhs_reg})
                    begin
                        if (k_reg != 4'd0)
                        begin
                            phase_reg <= sard_pkg::PH_REM;
                            bits_left_reg <= {1'b0, k_reg};
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                sard_pkg::S_FIN:
                    if (fin_go)
                    begin
                        if (pvalid_reg)
                        begin
                            ores_reg <= pres_reg;
                            oband_reg <= pband_reg;
                            odone_reg <= pdone_reg;
                            olast_reg <= 1'b0;
                        end
                        pvalid_reg <= 1'b1;
                        pres_reg <= pval_reg;
                        pband_reg <= 8'(bidx_reg);
                        pdone_reg <= 1'b0;
                        pval_reg <= '0;
                        ucnt_reg <= '0;
                        if (pix_reg + 25'd1 >= eff_pix)
                        begin
                            pix_reg <= '0;
                            if (bidx_reg + BW'(1) >= eff_bands)
                            begin
                                bidx_reg <= '0;
                                done_reg <= 1'b1;
                                pdone_reg <= 1'b1;
                                phase_reg <= sard_pkg::PH_IDLE;
                                bits_left_reg <= '0;
                            end
                            else
                            begin
                                bidx_reg <= bidx_reg + BW'(1);
                                phase_reg <= sard_pkg::PH_RAW;
                                bits_left_reg <= eff_d;
                            end
                        end
                        else
                        begin
                            pix_reg <= pix_reg + 25'd1;
                            phase_reg <= sard_pkg::PH_UNARY;
                            bits_left_reg <= '0;
                        end
                    end
                sard_pkg::S_EMIT:
                    if (out_free)
                    begin
                        ores_reg <= pres_reg;
                        oband_reg <= pband_reg;
                        odone_reg <= pdone_reg;
                        olast_reg <= 1'b1;
                        pvalid_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // payload-side datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == sard_pkg::S_WAIT && in_valid) sh_reg <= compressed_byte;
        else if (state_reg == sard_pkg::S_BIT && more_bits) sh_reg <= sh_reg << 1;
        if (state_reg == sard_pkg::S_KCMP) ck_reg <= ck_reg << 1;
        if (state_reg == sard_pkg::S_KRD)
        begin
            ck_reg <= 44'(rcount);
            rhs_reg <= {1'b0, raccum} + 33'((18'd49 * 18'(rcount)) >> 7);
        end
        if (state_reg == sard_pkg::S_BIT) begin cnt_reg <= rcount; acc_reg <= raccum; end
        if (state_reg == sard_pkg::S_KCMP) begin cnt_reg <= rcount; acc_reg <= raccum; end
    end

    assign out_valid = ovalid_reg;
    assign residual = ores_reg;
    assign band = oband_reg;
    assign last_of_byte = olast_reg && ovalid_reg;
    assign image_done = odone_reg && ovalid_reg;

    `SARD_ASSERT_IMP(a_no_accept_busy, in_valid && in_ready, state_reg == sard_pkg::S_WAIT)
    `SARD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(residual))
    `SARD_ASSERT_IMP(a_done_idle, done_reg && state_reg == sard_pkg::S_BIT,
                     phase_reg == sard_pkg::PH_IDLE)
endmodule

// ===== dv/sample_adaptive_residual_decoder_unit_tb.sv =====
// Testbench for sample_adaptive_residual_decoder_unit: drives begin commands and compressed bytes,
// predicts decoded residuals in a scoreboard class and checks every output transfer.
// Depends on sard_pkg and the decoder RTL.
`timescale 1ns / 1ps
module sample_adaptive_residual_decoder_unit_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 800;
    localparam int RANDOM_ITEMS = 210;

    typedef struct packed {
        logic [15:0] residual;
        logic [7:0]  band;
        logic        last;
        logic        done;
    } residual_t;

    class residual_scoreboard;
        int unsigned pixels, bands, drange, umax, resc, icnt, ik;
        int unsigned band_cnt[256];
        int unsigned band_acc[256];
        sard_pkg::phase_t phase;
        int unsigned bits_left, ucnt, pval, pix, bidx;
        residual_t   expected_q[$];
        int          errors;

        function new();
            pixels = 1; bands = 1; drange = 16; umax = 32;
            resc = 4; icnt = 8; ik = 0;
            phase = sard_pkg::PH_IDLE;
            bits_left = 0; ucnt = 0; pval = 0; pix = 0; bidx = 0;
            errors = 0;
        endfunction

        function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(logic [2:0] idx, logic [24:0] val);
            case (idx)
                sard_pkg::REG_PIXELS: pixels = val;
                sard_pkg::REG_BANDS:  bands = val[8:0];
                sard_pkg::REG_DRANGE: drange = val[4:0];
                sard_pkg::REG_UMAX:   umax = val[5:0];
                sard_pkg::REG_RESC:   resc = val[3:0];
                sard_pkg::REG_ICNT:   icnt = val[3:0];
                sard_pkg::REG_IK:     ik = val[3:0];
                default: ;
            endcase
        endfunction

        function void start_sample();
            pval = 0;
            ucnt = 0;
            if (pix == 0) begin
                phase = sard_pkg::PH_RAW;
                bits_left = clampu(drange, 2, 16);
            end
            else begin
                phase = sard_pkg::PH_UNARY;
                bits_left = 0;
            end
        endfunction

        function void note_input(logic cmd, logic [7:0] data);
            residual_t         batch[$];
            residual_t         r;
            int unsigned       c0, k, kmax, lim;
            longint unsigned   a0, c, rhs;
            bit                complete, done, bitv;
            if (cmd == sard_pkg::CMD_BEGIN) begin
                c0 = 1 << clampu(icnt, 1, 8);
                a0 = (longint'(c0) * (3 * (longint'(64) << ik) - 49)) >> 7;
                for (int i = 0; i < clampu(bands, 1, 256); i++) begin
                    band_cnt[i] = c0;
                    band_acc[i] = a0[31:0];
                end
                pix = 0;
                bidx = 0;
                start_sample();
                return;
            end
            for (int i = 0; i < 8 && phase != sard_pkg::PH_IDLE; i++) begin
                bitv = data[7-i];
                complete = 0;
                if (phase == sard_pkg::PH_RAW || phase == sard_pkg::PH_REM) begin
                    pval = ((pval << 1) | bitv) & 16'hFFFF;
                    if (bits_left > 0)
                        bits_left--;
                    if (bits_left == 0)
                        complete = 1;
                end
                else if (!bitv) begin
                    ucnt++;
                    if (ucnt >= clampu(umax, 1, 32)) begin
                        phase = sard_pkg::PH_RAW;
                        bits_left = clampu(drange, 2, 16);
                        pval = 0;
                    end
                end
                else begin
                    c = band_cnt[bidx];
                    rhs = longint'(band_acc[bidx]) + ((49 * c) >> 7);
                    kmax = clampu(drange, 2, 16) - 2;
                    k = 0;
                    while (k < kmax && (c << (k + 1)) <= rhs)
                        k++;
                    pval = ucnt & 16'hFFFF;
                    if (k == 0)
                        complete = 1;
                    else begin
                        phase = sard_pkg::PH_REM;
                        bits_left = k;
                    end
                end
                if (complete) begin
                    if (pix != 0) begin
                        lim = (1 << clampu(resc, 4, 11)) - 1;
                        if (band_cnt[bidx] < lim) begin
                            band_acc[bidx] = band_acc[bidx] + pval;
                            band_cnt[bidx] = band_cnt[bidx] + 1;
                        end
                        else begin
                            a0 = (longint'(band_acc[bidx]) + pval + 1) >> 1;
                            band_acc[bidx] = a0[31:0];
                            band_cnt[bidx] = (band_cnt[bidx] + 1) >> 1;
                        end
                        band_cnt[bidx] &= 11'h7FF;
                    end
                    r.residual = pval[15:0];
                    r.band = bidx[7:0];
                    r.last = 0;
                    done = 0;
                    pix++;
                    if (pix >= clampu(pixels, 1, 16777216)) begin
                        pix = 0;
                        bidx++;
                        if (bidx >= clampu(bands, 1, 256)) begin
                            bidx = 0;
                            done = 1;
                        end
                    end
                    if (done) begin
                        phase = sard_pkg::PH_IDLE;
                        bits_left = 0;
                        ucnt = 0;
                        pval = 0;
                    end
                    else
                        start_sample();
                    r.done = done;
                    batch.push_back(r);
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1;
            foreach (batch[i])
                expected_q.push_back(batch[i]);
        endfunction

        function void check_result(residual_t got);
            residual_t exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: residual %0d band %0d last %0d done %0d",
                             got.residual, got.band, got.last, got.done);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp residual %0d band %0d last %0d done %0d, got %0d %0d %0d %0d",
                             exp_r.residual, exp_r.band, exp_r.last, exp_r.done,
                             got.residual, got.band, got.last, got.done);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [24:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [7:0]  compressed_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] residual;
    logic [7:0]  band;
    logic        last_of_byte;
    logic        image_done;

    residual_scoreboard sb;
    int  idle_cycles = 0;
    int  items_sent;
    bit  send_burst;
    bit  recv_burst;
    bit  hold_req;

    sample_adaptive_residual_decoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .compressed_byte(compressed_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .residual(residual), .band(band),
        .last_of_byte(last_of_byte), .image_done(image_done)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one transfer; called at a falling edge, returns at a falling edge
    task automatic send_item(logic cmd, logic [7:0] data);
        int gap;
        gap = send_burst ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        compressed_byte <= data;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(cmd, data);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_config(int unsigned v0, int unsigned v1, int unsigned v2,
                                int unsigned v3, int unsigned v4, int unsigned v5,
                                int unsigned v6);
        logic [24:0] vals[7];
        vals = '{25'(v0), 25'(v1), 25'(v2), 25'(v3), 25'(v4), 25'(v5), 25'(v6)};
        in_valid <= 0;
        while (sb.expected_q.size() != 0 || !in_ready)
            @(negedge clk);
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            sb.write_reg(i[2:0], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'($urandom_range(0, 255));
        if (r < 8)
            return 8'($urandom_range(0, 255) | $urandom_range(0, 255));
        return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
    endfunction

    // receiver with random stalls and one long hold
    initial begin
        int gap;
        int hold;
        bit hold_taken;
        gap = 0;
        hold = 0;
        hold_taken = 0;
        out_ready = 0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold = HOLD_CYCLES;
                hold_taken = 1;
            end
            if (hold > 0) begin
                out_ready <= 0;
                hold--;
            end
            else if (gap > 0) begin
                out_ready <= 0;
                gap--;
            end
            else begin
                out_ready <= 1;
                if (!recv_burst && $urandom_range(0, 3) == 0)
                    gap = gap_len();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{residual, band, last_of_byte, image_done});
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int nbytes;
        int phase_no;
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        command = 0;
        compressed_byte = 0;
        items_sent = 0;
        send_burst = 0;
        recv_burst = 0;
        hold_req = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // bytes before any begin are dropped
        send_item(sard_pkg::CMD_BYTE, 8'hA5);
        write_config(3, 2, 4, 2, 4, 1, 0);
        send_item(sard_pkg::CMD_BEGIN, 8'h00);
        send_item(sard_pkg::CMD_BYTE, 8'hFF);
        send_item(sard_pkg::CMD_BYTE, 8'h00);
        send_item(sard_pkg::CMD_BYTE, 8'h00);
        send_item(sard_pkg::CMD_BYTE, 8'h55);
        // restart mid-image
        send_item(sard_pkg::CMD_BEGIN, 8'hFF);
        send_item(sard_pkg::CMD_BYTE, 8'hAA);
        send_item(sard_pkg::CMD_BYTE, 8'hFF);
        send_item(sard_pkg::CMD_BYTE, 8'hFF);
        send_item(sard_pkg::CMD_BYTE, 8'h0F);
        // upper extremes and out-of-range clamping
        write_config(25'h1FFFFFF, 9'h1FF, 31, 63, 15, 15, 15);
        send_item(sard_pkg::CMD_BEGIN, 8'h00);
        for (int i = 0; i < 4; i++)
            send_item(sard_pkg::CMD_BYTE, 8'h00);
        send_item(sard_pkg::CMD_BYTE, 8'hFF);
        send_item(sard_pkg::CMD_BYTE, 8'h80);
        send_item(sard_pkg::CMD_BYTE, 8'hFF);
        // lower extremes; image completes mid-byte, later bytes dropped
        write_config(0, 0, 0, 0, 0, 0, 0);
        send_item(sard_pkg::CMD_BEGIN, 8'h00);
        send_item(sard_pkg::CMD_BYTE, 8'hC3);
        send_item(sard_pkg::CMD_BYTE, 8'h12);

        phase_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase_no == 2)
                write_config(64, 4, 8, 4, 6, 4, 2);
            else if ($urandom_range(0, 9) == 0)
                write_config($urandom_range(0, 25'h1FFFFFF), $urandom_range(0, 511),
                             $urandom_range(0, 31), $urandom_range(0, 63),
                             $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 15));
            else
                write_config($urandom_range(1, 8), $urandom_range(1, 5),
                             $urandom_range(2, 16), $urandom_range(1, 32),
                             $urandom_range(4, 11), $urandom_range(1, 8),
                             $urandom_range(0, 15));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (phase_no == 2) begin
                send_burst = 1;
                hold_req = 1;
            end
            send_item(sard_pkg::CMD_BEGIN, 8'h00);
            nbytes = $urandom_range(8, 30);
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(sard_pkg::CMD_BEGIN, rand_byte());
                else
                    send_item(sard_pkg::CMD_BYTE, rand_byte());
            end
            phase_no++;
        end
        in_valid <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
